/* hdl/session_timeout_table_top_defines.svh */
// ----------------------------------------------------------------------------
// Session timeout table: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SESSION_TIMEOUT_TABLE_TOP_DEFINES_SVH
`define SESSION_TIMEOUT_TABLE_TOP_DEFINES_SVH

// Plain property checked on every clock edge outside reset.
`define STS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Signal holds its value into the next cycle whenever cond is true.
`define STS_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> $stable(sig)) \
    else $error(msg);

`endif

/* hdl/sts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session timeout table package
// Shared types, codes and reset constants.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned AGE_W      = 4;
  localparam int unsigned IDLE_W     = 5;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [AGE_W-1:0]  TIMEOUT_RST    = 4'd10;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 5'd20;
  localparam logic [IDLE_W-1:0] IDLE_MAX       = 5'd31;
  localparam logic [CNT_W-1:0]  COUNT_MAX      = 5'd31;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_TICK     = 2'd2,
    OP_OTHER    = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TIMEOUT    = 1'b0,
    REG_IDLE_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_TICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [ID_W-1:0]  tag;
  } slot_t;

endpackage

`default_nettype wire

/* hdl/sts_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session timeout table channels
// Valid/ready interfaces for the item and result channels.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic                       valid;
  logic                       ready;
  logic [sts_pkg::OP_W-1:0]   opcode;
  logic [sts_pkg::ID_W-1:0]   response_id;

  modport source (output valid, output opcode, output response_id, input ready);
  modport sink   (input valid, input opcode, input response_id, output ready);
endinterface

interface sts_out_if;
  logic                       valid;
  logic                       ready;
  logic [sts_pkg::ID_W-1:0]   assigned_id;
  logic                       hit;
  logic [sts_pkg::CNT_W-1:0]  evicted_count;
  logic                       shutdown;

  modport source (output valid, output assigned_id, output hit, output evicted_count,
                  output shutdown, input ready);
  modport sink   (input valid, input assigned_id, input hit, input evicted_count,
                  input shutdown, output ready);
endinterface

`default_nettype wire

/* hdl/session_timeout_table_top.sv */
// A register or other item goes from accept to the done state; a response first
// computes its slot index (a mask when SLOTS is a power of two, else a reciprocal
// multiply), then reads and checks that slot; a tick sweeps the slot memory, one
// slot per cycle. One item is in work at a time; the next is taken when the previous
// result is parked in the output register. After reset a clearing pass zeroes every
// slot of the slot memory before the first item is accepted.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session timeout table
// Pending-session table with ageing eviction and idle shutdown flag.
// ----------------------------------------------------------------------------
module session_timeout_table_top #(
  parameter int unsigned SLOTS = sts_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sts_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  sts_in_if.sink                         in_ch,
  sts_out_if.source                      out_ch
);
  import sts_pkg::*;

  localparam int unsigned IW       = $clog2(SLOTS);
  localparam int unsigned CW       = IW + 1;
  localparam logic [IW-1:0] LastSlot = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SweepEnd = CW'(SLOTS);

  state_t state, state_next;

  logic [AGE_W-1:0]  timeout_ticks;
  logic [IDLE_W-1:0] idle_limit;
  logic [ID_W-1:0]   next_session;
  logic [IW-1:0]     next_slot;
  logic [IDLE_W-1:0] idle_ticks;
  logic [IDLE_W-1:0] idle_inc;
  logic              stop_flag;

  logic [ID_W-1:0]   rid;
  logic [IW-1:0]     slot_idx;
  logic [IW-1:0]     clr_idx;
  logic [CW-1:0]     sweep_idx;
  logic              pend;
  logic [IW-1:0]     pend_idx;

  logic [ID_W-1:0]   asg_id;
  logic              hit_r;
  logic [CNT_W-1:0]  evc_cnt;

  logic              res_valid;
  logic              res_free;
  logic [ID_W-1:0]   res_id;
  logic              res_hit;
  logic [CNT_W-1:0]  res_evc;
  logic              res_stop;

  logic              accept;
  op_t               op;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  slot_t             mem_wdata;
  logic [IW-1:0]     mem_raddr;
  logic [$bits(slot_t)-1:0] mem_rdata;
  slot_t             rd;

  logic              mod_start;
  logic              mod_done;
  logic [IW-1:0]     mod_rem;

  logic [AGE_W:0]    age_inc;
  logic              expire;
  logic              tag_hit;
  slot_t             tick_entry;

  assign op       = op_t'(in_ch.opcode);
  assign in_ch.ready = (state == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign res_free = !res_valid || out_ch.ready;
  assign rd       = slot_t'(mem_rdata);

  assign out_ch.valid         = res_valid;
  assign out_ch.assigned_id   = res_id;
  assign out_ch.hit           = res_hit;
  assign out_ch.evicted_count = res_evc;
  assign out_ch.shutdown      = res_stop;

  assign idle_inc = (idle_ticks == IDLE_MAX) ? IDLE_MAX : idle_ticks + 1'b1;

  // tick update of one slot read back from memory
  assign age_inc = {1'b0, rd.age} + 1'b1;
  assign expire  = rd.valid && (age_inc >= {1'b0, timeout_ticks});
  assign tag_hit = rd.valid && (rd.tag == rid);

  always_comb begin
    tick_entry = rd;
    if (expire) begin
      tick_entry.valid = 1'b0;
      tick_entry.age   = '0;
    end else if (rd.valid) begin
      tick_entry.age = age_inc[AGE_W-1:0];
    end
  end

  sts_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(slot_t)),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sts_slot_mod #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .id    (in_ch.response_id),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = slot_idx;
    mem_wdata  = '0;
    mem_raddr  = slot_idx;
    mod_start  = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        if (clr_idx == LastSlot) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_REGISTER: begin
              mem_we          = 1'b1;
              mem_waddr       = next_slot;
              mem_wdata.valid = 1'b1;
              mem_wdata.tag   = next_session;
              state_next      = S_DONE;
            end
            OP_RESPONSE: begin
              mod_start  = 1'b1;
              state_next = S_MOD;
            end
            OP_TICK: begin
              state_next = S_TICK;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // a hit frees the slot
        if (tag_hit) begin
          mem_we        = 1'b1;
          mem_wdata     = rd;
          mem_wdata.valid = 1'b0;
          mem_wdata.age = '0;
        end
        state_next = S_DONE;
      end
      S_TICK: begin
        // read slot i while slot i-1 is written back
        mem_raddr = sweep_idx[IW-1:0];
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx;
          mem_wdata = tick_entry;
        end else if (sweep_idx == SweepEnd) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
      idle_limit    <= IDLE_LIMIT_RST;
      next_session  <= '0;
      next_slot     <= '0;
      idle_ticks    <= '0;
      stop_flag     <= 1'b0;
      clr_idx       <= '0;
      pend          <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_addr))
          REG_TIMEOUT:    timeout_ticks <= cfg_wdata[AGE_W-1:0];
          REG_IDLE_LIMIT: idle_limit    <= cfg_wdata[IDLE_W-1:0];
          default: ;
        endcase
      end

      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end

      if (accept) begin
        case (op)
          OP_REGISTER: begin
            next_session <= next_session + 1'b1;
            // id wrap restarts the slot sequence at zero
            next_slot    <= (next_session == '1 || next_slot == LastSlot) ? '0
                                                                          : next_slot + 1'b1;
            idle_ticks   <= '0;
          end
          OP_TICK: begin
            idle_ticks <= idle_inc;
            if (idle_inc > idle_limit) begin
              stop_flag <= 1'b1;
            end
          end
          default: begin
            idle_ticks <= '0;
          end
        endcase
      end

      if (accept) begin
        pend <= 1'b0;
      end else if (state == S_TICK) begin
        pend <= (sweep_idx != SweepEnd);
      end

      if (state == S_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rid       <= in_ch.response_id;
      asg_id    <= (op == OP_REGISTER) ? next_session : '0;
      hit_r     <= 1'b0;
      evc_cnt   <= '0;
      sweep_idx <= '0;
    end
    if (state == S_MOD && mod_done) begin
      slot_idx <= mod_rem;
    end
    if (state == S_CHECK) begin
      hit_r <= tag_hit;
    end
    if (state == S_TICK) begin
      if (sweep_idx != SweepEnd) begin
        pend_idx  <= sweep_idx[IW-1:0];
        sweep_idx <= sweep_idx + 1'b1;
      end
      if (pend && expire && evc_cnt != COUNT_MAX) begin
        evc_cnt <= evc_cnt + 1'b1;
      end
    end
    if (state == S_DONE && res_free) begin
      res_id   <= asg_id;
      res_hit  <= hit_r;
      res_evc  <= evc_cnt;
      res_stop <= stop_flag;
    end
  end

endmodule

`default_nettype wire

/* hdl/sts_slot_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sts_slot_ram #(
  parameter int unsigned DEPTH = sts_pkg::SLOTS_DEF,
  parameter int unsigned WIDTH = $bits(sts_pkg::slot_t),
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/sts_slot_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot index unit
// id mod SLOTS: a mask for power-of-two tables, else a reciprocal multiply
// in registered steps: low partial product, quotient, remainder.
// ----------------------------------------------------------------------------
module sts_slot_mod #(
  parameter int unsigned SLOTS = sts_pkg::SLOTS_DEF,
  parameter int unsigned IW    = $clog2(SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [sts_pkg::ID_W-1:0] id,
  output logic                     done,
  output logic [IW-1:0]            rem
);
  import sts_pkg::*;

  localparam bit Pow2 = (SLOTS & (SLOTS - 1)) == 0;
  // ceil(2^(32+IW) / SLOTS) fits 33 bits and gives the exact quotient of any id
  localparam logic [63:0] Recip =
    ((64'd1 << (ID_W + IW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [15:0]   RecipHi = Recip[32:17];
  localparam logic [16:0]   RecipLo = Recip[16:0];
  localparam logic [IW-1:0] SlotsLo = IW'(SLOTS);

  logic [ID_W-1:0]  idr;
  logic [ID_W+16:0] prod_lo;
  logic [ID_W+15:0] prod_hi;
  logic [ID_W+33:0] prod;
  logic [IW-1:0]    quot;
  logic [IW-1:0]    quot_x_slots;
  logic [IW-1:0]    acc;
  logic             s1;
  logic             s2;
  logic             s3;

  // only the low IW bits of the quotient matter: the remainder is below SLOTS
  assign prod_hi      = idr * RecipHi;
  assign prod         = {1'b0, prod_hi, 17'b0} + {17'b0, prod_lo};
  assign quot_x_slots = quot * SlotsLo;
  assign rem          = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      s3   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= start && !Pow2;
      s2   <= s1;
      s3   <= s2;
      done <= Pow2 ? start : s3;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idr <= id;
    end
    if (s1) begin
      prod_lo <= idr * RecipLo;
    end
    if (s2) begin
      quot <= prod[ID_W+IW +: IW];
    end
    if (start) begin
      acc <= id[IW-1:0];
    end else if (s3) begin
      acc <= idr[IW-1:0] - quot_x_slots;
    end
  end

endmodule

`default_nettype wire

/* hdl/sts_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session timeout table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "session_timeout_table_top_defines.svh"

module sts_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [sts_pkg::ID_W-1:0]  out_assigned_id,
  input wire logic                     out_hit,
  input wire logic [sts_pkg::CNT_W-1:0] out_evicted_count,
  input wire logic                     out_shutdown
);

  `STS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `STS_ASSERT_HOLD(a_id_hold, out_valid && !out_ready, out_assigned_id, "stalled id changed")
  `STS_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
  `STS_ASSERT(a_sticky, out_valid && out_shutdown |=> out_shutdown, "shutdown flag cleared")
  `STS_ASSERT(a_hit_only, out_valid && out_hit |-> out_assigned_id == '0 && out_evicted_count == '0, "hit result carries other fields")

endmodule

bind session_timeout_table_top sts_checker u_sts_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_assigned_id   (out_ch.assigned_id),
  .out_hit           (out_ch.hit),
  .out_evicted_count (out_ch.evicted_count),
  .out_shutdown      (out_ch.shutdown)
);

`default_nettype wire
